@@ src/totp_code_generator_defines.svh @@
// Assertion macros for the TOTP code generator.
// Included by files that carry concurrent assertions.
`ifndef TOTP_CODE_GENERATOR_DEFINES_SVH
`define TOTP_CODE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TOTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TOTP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TOTP_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ src/totp_pkg.sv @@
// Shared constants, types and functions for the TOTP code generator.
// No dependencies.
`default_nettype none
package totp_pkg;
    localparam int MAX_KEY_BYTES = 32;
    localparam int TIME_W  = 63;
    localparam int CODE_W  = 30;
    localparam int STEP_W  = 17;
    localparam int KLEN_W  = 6;
    localparam int DIG_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KLEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIGS = 3'd6;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // Control from sequencer to compression core
    typedef struct packed {
        logic start;
        logic init;  // load IV instead of chaining
    } t_sha_ctl;

    function automatic logic [29:0] pow10(input logic [3:0] d);
        logic [29:0] r;
        case (d)
            4'd0: r = 30'd1;
            4'd1: r = 30'd10;
            4'd2: r = 30'd100;
            4'd3: r = 30'd1000;
            4'd4: r = 30'd10000;
            4'd5: r = 30'd100000;
            4'd6: r = 30'd1000000;
            4'd7: r = 30'd10000000;
            4'd8: r = 30'd100000000;
            default: r = 30'd1000000000;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

@@ src/totp_sha1_core.sv @@
// SHA-1 compression core: one round per cycle, 16-word message schedule window.
// Depends on totp_pkg.
`default_nettype none
module totp_sha1_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire totp_pkg::t_sha_ctl i_ctl,
    input  wire logic [511:0]      i_block,
    output logic [159:0]           o_hash,
    output logic                   o_done
);
    import totp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD} t_state;
    t_state r_state;
    logic [6:0] r_rnd;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h;
    logic r_done;

    logic [31:0] f, k, t, wn;

    always_comb begin
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = 32'h5A827999;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = 32'h6ED9EBA1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = 32'h8F1BBCDC;
        end else begin
            f = r_b ^ r_c ^ r_d; k = 32'hCA62C1D6;
        end
        t  = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_w[0];
        wn = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        wn = {wn[30:0], wn[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_rnd   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        for (int i = 0; i < 16; i++)
                            r_w[i] <= i_block[511 - 32*i -: 32];
                        if (i_ctl.init) begin
                            r_h <= SHA1_IV;
                            {r_a, r_b, r_c, r_d, r_e} <= SHA1_IV;
                        end else begin
                            {r_a, r_b, r_c, r_d, r_e} <= r_h;
                        end
                        r_rnd   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wn;
                    r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a; r_a <= t;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                            r_h[63:32] + r_d, r_h[31:0] + r_e};
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_hash = r_h;
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ src/totp_divider.sv @@
// Restoring bit-serial divider, one quotient bit per cycle; also serves modulo.
// Depends on totp_pkg.
`default_nettype none
module totp_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem,
    output logic             o_done
);
    import totp_pkg::*;

    logic [63:0] r_q;
    logic [32:0] r_r;
    logic [31:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] sh, df;

    assign sh = {r_r[31:0], r_q[63]};
    assign df = sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_q <= i_dividend; r_r <= '0; r_d <= i_divisor;
                r_cnt <= '0; r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!df[32]) begin
                    r_r <= df; r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= sh; r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r[31:0];
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ src/totp_code_generator.sv @@
// Top level of the TOTP code generator: config registers, sequencer, output register.
// Depends on totp_pkg, totp_sha1_core, totp_divider and the defines header.
`default_nettype none
`include "totp_code_generator_defines.svh"
// One time value in, one code out. The block takes an item, divides it by the
// time step in the shared divider, runs four SHA-1 compressions in the
// one-round-per-cycle core, and reduces the truncated value modulo ten to the
// digit count in the same divider; s_axis_tready stays low until the code is
// loaded into the output register. A result not yet taken holds the block
// before it loads the next code. The result waits in an output register until
// taken; configuration is written through the plain write port, which the user
// must do only while idle; the block itself does not enforce this.
module totp_code_generator #(
    parameter int MAX_KEY_BYTES = totp_pkg::MAX_KEY_BYTES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [totp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [totp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata,  // [62:0] unix_time
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [31:0]                        m_axis_tdata   // [29:0] otp_code
);
    import totp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_DIVW, S_HI1, S_HI2, S_HO1, S_HO2, S_MOD, S_MODW, S_OUT
    } t_state;

    logic [63:0] r_key [4];
    logic [KLEN_W-1:0] r_klen;
    logic [STEP_W-1:0] r_step;
    logic [DIG_W-1:0]  r_digs;

    t_state r_state;
    logic [63:0] r_ctr;
    logic [159:0] r_ih;
    logic [29:0] r_code;
    logic r_ovalid;
    t_sha_ctl r_sctl;
    logic [511:0] r_blk;
    logic r_dstart;
    logic [63:0] r_dvd;
    logic [31:0] r_dvs;

    logic [159:0] hash;
    logic sdone, ddone;
    logic [63:0] quot;
    logic [31:0] drem;

    // Key block padded with zeros and XORed with a pad byte
    logic [255:0] kbits, kmask;
    logic [5:0] klen_sat;
    always_comb begin
        klen_sat = (r_klen > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : r_klen;
        kbits = {r_key[0], r_key[1], r_key[2], r_key[3]};
        for (int i = 0; i < 32; i++)
            kmask[255 - 8*i -: 8] = (6'(i) < klen_sat) ? 8'hFF : 8'h00;
        kbits = kbits & kmask;
    end

    logic [511:0] ipad_blk, opad_blk;
    assign ipad_blk = {kbits, 256'h0} ^ {64{8'h36}};
    assign opad_blk = {kbits, 256'h0} ^ {64{8'h5C}};

    // Dynamic truncation
    logic [3:0]  off;
    logic [31:0] bin;
    assign off = hash[3:0];
    assign bin = {1'b0, hash[158 - 8*off -: 31]};
    logic [3:0] dsat;
    assign dsat = (r_digs > 4'd9) ? 4'd9 : r_digs;

    totp_sha1_core u_sha (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_sctl), .i_block(r_blk),
        .o_hash(hash), .o_done(sdone)
    );

    totp_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_dividend(r_dvd), .i_divisor(r_dvs),
        .o_quot(quot), .o_rem(drem), .o_done(ddone)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0; r_key[1] <= '0; r_key[2] <= '0; r_key[3] <= '0;
            r_klen <= 6'd20;
            r_step <= 17'd30;
            r_digs <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0: r_key[0] <= i_cfg_data;
                REG_KEY1: r_key[1] <= i_cfg_data;
                REG_KEY2: r_key[2] <= i_cfg_data;
                REG_KEY3: r_key[3] <= i_cfg_data;
                REG_KLEN: r_klen <= i_cfg_data[KLEN_W-1:0];
                REG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                REG_DIGS: r_digs <= i_cfg_data[DIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sctl   <= '0;
            r_dstart <= 1'b0;
        end else begin
            r_sctl   <= '0;
            r_dstart <= 1'b0;
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_dvd <= {1'b0, s_axis_tdata[62:0]};
                        r_dvs <= (r_step == '0) ? 32'd1 : {15'd0, r_step};
                        r_dstart <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (ddone) begin
                        r_ctr <= quot;
                        r_blk <= ipad_blk;
                        r_sctl <= '{start: 1'b1, init: 1'b1};
                        r_state <= S_HI1;
                    end
                end
                S_HI1: begin
                    if (sdone) begin
                        // counter, pad bit, length 72 bytes
                        r_blk <= {r_ctr, 8'h80, 376'd0, 64'd576};
                        r_sctl <= '{start: 1'b1, init: 1'b0};
                        r_state <= S_HI2;
                    end
                end
                S_HI2: begin
                    if (sdone) begin
                        r_ih <= hash;
                        r_blk <= opad_blk;
                        r_sctl <= '{start: 1'b1, init: 1'b1};
                        r_state <= S_HO1;
                    end
                end
                S_HO1: begin
                    if (sdone) begin
                        // inner digest, pad bit, length 84 bytes
                        r_blk <= {r_ih, 8'h80, 280'd0, 64'd672};
                        r_sctl <= '{start: 1'b1, init: 1'b0};
                        r_state <= S_HO2;
                    end
                end
                S_HO2: begin
                    if (sdone) begin
                        r_dvd <= {32'd0, bin};
                        r_dvs <= {2'b0, pow10(dsat)};
                        r_dstart <= 1'b1;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (ddone) r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the remainder in the divider until the output is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_code  <= drem[29:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_code};

    `TOTP_ASSERT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "result changed while stalled")
    `TOTP_ASSERT(a_code_range, i_clk, i_rst_n,
        m_axis_tvalid |-> m_axis_tdata[29:0] < 30'd1000000000, "code out of range")
    `TOTP_ASSERT(a_busy, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> !s_axis_tready, "ready while busy")
endmodule
`default_nettype wire
